// ===== design/pwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwc_pkg
// Types and constants shared by the pulse width capture block.
// ----------------------------------------------------------------------------
package pwc_pkg;

  // field widths
  localparam int CH_W    = 2;
  localparam int CAP_W   = 16;
  localparam int CNT_W   = 16;
  localparam int WIDTH_W = 32;
  localparam int AWAIT_W = 4;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 16;

  // packed bus widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_WRAP_WEIGHT = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_OVF_LIMIT   = 1'd1;

  // register reset values
  localparam logic [CFG_D_W-1:0] WRAP_WEIGHT_RST = 16'd4999;
  localparam logic [CFG_D_W-1:0] OVF_LIMIT_RST   = 16'd63;

  // event kinds
  localparam logic MODE_WRAP    = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

  // command from the control stage to one channel
  typedef struct packed {
    logic             step;     // apply this cycle
    logic             wrap;     // counter wrap event
    logic             capture;  // capture addressed to this channel
    logic [CAP_W-1:0] cap_value;
  } chan_cmd_t;

  // state of one channel
  typedef struct packed {
    logic             is_high;
    logic [CNT_W-1:0] ovf_count;
    logic [CAP_W-1:0] rise_value;
  } chan_state_t;

endpackage

// ===== design/multi_channel_pulse_width_capture.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pulse_width_capture
// High pulse width measurement on several channels from wrap and capture words.
// ----------------------------------------------------------------------------
// Registers: input, then result; channel update and one 16x16 multiply sit in one stage.
// Throughput: one word per cycle while out_tready is high.
// Each input word yields exactly one result word.
// Reset: synchronous active-low rst_n clears channel state, pipeline valids and
// restores wrap_weight to 4999 and overflow_limit to 63.
module multi_channel_pulse_width_capture #(
  parameter int CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pwc_pkg::IN_DATA_W-1:0]       in_tdata,   // channel[1:0], capture_value[17:2]
  input  logic                                in_tuser,   // mode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pwc_pkg::OUT_DATA_W-1:0]      out_tdata,  // width_channel[1:0],
                                                          // pulse_width[33:2],
                                                          // await_falling[37:34]
  output logic                                out_tuser,  // width_valid
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [pwc_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [pwc_pkg::CFG_D_W-1:0]         cfg_wr_data
);
  import pwc_pkg::*;

  // configuration registers
  logic [CFG_D_W-1:0] wrap_weight_r;
  logic [CFG_D_W-1:0] ovf_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_weight_r <= WRAP_WEIGHT_RST;
      ovf_limit_r   <= OVF_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_WRAP_WEIGHT: wrap_weight_r <= cfg_wr_data;
        REG_OVF_LIMIT:   ovf_limit_r   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_r;
  logic             mode_r;
  logic [CH_W-1:0]  ch_r;
  logic [CAP_W-1:0] cap_r;
  logic             advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r <= in_tuser;
      ch_r   <= in_tdata[CH_W-1:0];
      cap_r  <= in_tdata[CH_W+CAP_W-1:CH_W];
    end
  end

  // channel cells
  chan_state_t        ch_state [CHANNELS];
  logic [CHANNELS-1:0] hi_nxt;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_cmd_t cmd;
    assign cmd.step      = advance;
    assign cmd.wrap      = (mode_r == MODE_WRAP);
    assign cmd.capture   = (mode_r == MODE_CAPTURE) && (int'(ch_r) == c);
    assign cmd.cap_value = cap_r;

    pwc_chan u_chan (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .ovf_limit   (ovf_limit_r),
      .state       (ch_state[c]),
      .is_high_nxt (hi_nxt[c])
    );
  end

  // pick the addressed channel
  chan_state_t sel_state;
  logic        ch_hit;

  always_comb begin
    sel_state = '0;
    ch_hit    = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(ch_r) == c) begin
        sel_state = ch_state[c];
        ch_hit    = 1'b1;
      end
    end
  end

  // width = fall - rise + overflows * weight, modulo 2^32
  logic                width_valid;
  logic [WIDTH_W-1:0]  ovf_ticks;
  logic [WIDTH_W-1:0]  width_raw;

  assign width_valid = (mode_r == MODE_CAPTURE) && ch_hit && sel_state.is_high;
  assign ovf_ticks   = WIDTH_W'(sel_state.ovf_count) * WIDTH_W'(wrap_weight_r);
  assign width_raw   = WIDTH_W'(cap_r) - WIDTH_W'(sel_state.rise_value) + ovf_ticks;

  // awaited edge of the visible channels, after this word
  logic [AWAIT_W-1:0] await_nxt;

  for (genvar c = 0; c < AWAIT_W; c++) begin : g_await
    if (c < CHANNELS) begin : g_on
      assign await_nxt[c] = hi_nxt[c];
    end else begin : g_off
      assign await_nxt[c] = 1'b0;
    end
  end

  // result register
  logic               out_valid_r;
  logic               width_valid_r;
  logic [CH_W-1:0]    width_ch_r;
  logic [WIDTH_W-1:0] pulse_width_r;
  logic [AWAIT_W-1:0] await_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      width_valid_r <= width_valid;
      width_ch_r    <= width_valid ? ch_r : '0;
      pulse_width_r <= width_valid ? width_raw : '0;
      await_r       <= await_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = width_valid_r;
  assign out_tdata  = OUT_DATA_W'({await_r, pulse_width_r, width_ch_r});

endmodule

// ===== design/pwc_chan.sv =====
// ----------------------------------------------------------------------------
// pwc_chan
// State of one capture channel: level, overflow count and rising value.
// ----------------------------------------------------------------------------
module pwc_chan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwc_pkg::chan_cmd_t         cmd,
  input  logic [pwc_pkg::CNT_W-1:0]  ovf_limit,
  output pwc_pkg::chan_state_t       state,
  output logic                       is_high_nxt
);
  import pwc_pkg::*;

  chan_state_t state_r;
  chan_state_t state_nxt;

  // next state for wrap or capture
  always_comb begin
    state_nxt = state_r;
    if (cmd.step) begin
      if (cmd.wrap) begin
        if (state_r.is_high) begin
          if (state_r.ovf_count >= ovf_limit) begin
            state_nxt.rise_value = '0;
            state_nxt.ovf_count  = '0;
          end else begin
            state_nxt.ovf_count = state_r.ovf_count + CNT_W'(1);
          end
        end
      end else if (cmd.capture) begin
        if (!state_r.is_high) begin
          state_nxt.rise_value = cmd.cap_value;
          state_nxt.is_high    = 1'b1;
        end else begin
          state_nxt.ovf_count = '0;
          state_nxt.is_high   = 1'b0;
        end
      end
    end
  end

  // channel state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state       = state_r;
  assign is_high_nxt = state_nxt.is_high;

endmodule
